// ----- hw/rtl/nfr_pkg.sv -----
// Shared types, register codes and pipeline stage map for the firing response block.
package nfr_pkg;

  // Response mode codes held in the mode register.
  typedef enum logic [1:0] {
    MODE_SIGMOID = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_QUAD    = 2'd2,
    MODE_CUBIC   = 2'd3
  } mode_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_SPREAD    = 3'd2,
    REG_MAX_RATE  = 3'd3,
    REG_COEF_A    = 3'd4,
    REG_COEF_B    = 3'd5,
    REG_COEF_C    = 3'd6,
    REG_COEF_D    = 3'd7
  } reg_idx_t;

  // Sigmoid settings handed to the sigmoid pipeline.
  typedef struct packed {
    logic signed [31:0] threshold;
    logic [30:0]        spread;
    logic [30:0]        max_rate;
  } sig_cfg_t;

  // Values that ride along the exponential series stages.
  typedef struct packed {
    logic [31:0]        rr;
    logic [5:0]         n;
    logic               zero;
    logic               dneg;
    logic signed [33:0] sum;
  } ser_side_t;

  // ln 2 in Q.16 and the point past which exp(-z) shifts out completely.
  localparam int unsigned LN2_Q16        = 45426;
  localparam int unsigned EXP_ZERO_LIMIT = 33 * LN2_Q16;

  localparam int SERIES_TERMS = 14;
  localparam int DIV_Z_STEPS  = 21;
  localparam int DIV_R_STEPS  = 31;

  // Stage map of the pipeline.
  localparam int S_DIV_Z     = 3;
  localparam int S_DIV_Z_END = S_DIV_Z + DIV_Z_STEPS;
  localparam int S_NR_END    = S_DIV_Z_END + 2;
  localparam int S_SER0      = S_NR_END + 1;
  localparam int S_SER_END   = S_SER0 + 3 * (SERIES_TERMS - 1);
  localparam int S_DEN       = S_SER_END + 1;
  localparam int S_NUM       = S_DEN + 1;
  localparam int PIPE_DEPTH  = S_NUM + DIV_R_STEPS;
  localparam int POLY_STAGE  = 8;

  // Reciprocals floor(2^36 / k) for the series term divisions.
  localparam int RECIP_SHIFT = 36;
  localparam logic [35:0] RECIP_Q36 [2:14] = '{
    36'((64'd1 << 36) / 2),  36'((64'd1 << 36) / 3),  36'((64'd1 << 36) / 4),
    36'((64'd1 << 36) / 5),  36'((64'd1 << 36) / 6),  36'((64'd1 << 36) / 7),
    36'((64'd1 << 36) / 8),  36'((64'd1 << 36) / 9),  36'((64'd1 << 36) / 10),
    36'((64'd1 << 36) / 11), 36'((64'd1 << 36) / 12), 36'((64'd1 << 36) / 13),
    36'((64'd1 << 36) / 14)
  };

endpackage

// ----- hw/rtl/nfr_sigmoid.sv -----
// Pipelined sigmoid datapath: divider, exponential series and rate divider.
module nfr_sigmoid
  import nfr_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] v_i,
  input  sig_cfg_t           cfg_i,
  output logic [30:0]        rate_o
);

  // Splits off three bits of z / ln2, starting at the given bit weight.
  function automatic logic [23:0] ln2_div3(input logic [20:0] z, input int top);
    logic [20:0] zr;
    logic [2:0]  q;
    zr = z;
    q  = '0;
    for (int i = 0; i < 3; i++) begin
      if (zr >= 21'(LN2_Q16 << (top - i))) begin
        zr       = zr - 21'(LN2_Q16 << (top - i));
        q[2 - i] = 1'b1;
      end
    end
    return {zr, q};
  endfunction

  logic signed [32:0] diff;
  logic [30:0]        sdiv;
  logic [32:0]        adiff_r;
  logic               dneg_r [2:S_NR_END];
  logic               ovf_r [S_DIV_Z:S_DIV_Z_END];
  logic [30:0]        dz_rem_r [S_DIV_Z:S_DIV_Z_END-1];
  logic [20:0]        dz_bits_r [S_DIV_Z:S_DIV_Z_END];
  logic [23:0]        nr_hi;
  logic [23:0]        nr_lo;
  logic [20:0]        nz_r;
  logic [2:0]         nhi_r;
  logic               zero_hi_r;
  logic               zero_lo_r;
  logic [15:0]        r_r;
  logic [5:0]         n_r;
  ser_side_t          side_r [S_SER0:S_SER_END];
  logic [31:0]        trm_r [1:SERIES_TERMS-1];
  logic [31:0]        x1_r [2:SERIES_TERMS];
  logic [31:0]        x2_r [2:SERIES_TERMS];
  logic [31:0]        q2_r [2:SERIES_TERMS];
  logic [32:0]        e_r;
  logic               dneg_den_r;
  logic [63:0]        num;
  logic [32:0]        dr_rem_r [S_NUM:PIPE_DEPTH-1];
  logic [30:0]        dr_bits_r [S_NUM:PIPE_DEPTH];
  logic [33:0]        den_r [S_NUM:PIPE_DEPTH-1];

  // Distance from the threshold, kept as sign and magnitude.
  assign diff = {v_i[31], v_i} - {cfg_i.threshold[31], cfg_i.threshold};
  assign sdiv = (cfg_i.spread == '0) ? 31'd1 : cfg_i.spread;

  always_ff @(posedge clk) begin
    if (en) begin
      adiff_r   <= diff[32] ? 33'(-diff) : 33'(diff);
      dneg_r[2] <= diff[32];
    end
  end

  // Divider setup: quotients of 2^21 or more flush the exponential to zero.
  always_ff @(posedge clk) begin
    if (en) begin
      dz_rem_r[S_DIV_Z]  <= {3'b000, adiff_r[32:5]};
      dz_bits_r[S_DIV_Z] <= {adiff_r[4:0], 16'h0000};
      ovf_r[S_DIV_Z]     <= {3'b000, adiff_r[32:5]} >= sdiv;
      dneg_r[S_DIV_Z]    <= dneg_r[2];
    end
  end

  // One restoring step per stage; quotient bits fill in from the bottom.
  for (genvar s = S_DIV_Z + 1; s <= S_DIV_Z_END; s++) begin : g_div_z
    logic [31:0] cat;
    logic        ge;
    assign cat = {dz_rem_r[s-1], dz_bits_r[s-1][20]};
    assign ge  = cat >= {1'b0, sdiv};
    always_ff @(posedge clk) begin
      if (en) begin
        dz_bits_r[s] <= {dz_bits_r[s-1][19:0], ge};
        ovf_r[s]     <= ovf_r[s-1];
        dneg_r[s]    <= dneg_r[s-1];
      end
    end
    if (s < S_DIV_Z_END) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dz_rem_r[s] <= ge ? 31'(cat - {1'b0, sdiv}) : cat[30:0];
        end
      end
    end
  end

  // Reduce z by ln 2: the upper three bits of n, then the lower three.
  assign nr_hi = ln2_div3(dz_bits_r[S_DIV_Z_END], 5);
  assign nr_lo = ln2_div3(nz_r, 2);

  always_ff @(posedge clk) begin
    if (en) begin
      nz_r                 <= nr_hi[23:3];
      nhi_r                <= nr_hi[2:0];
      zero_hi_r            <= ovf_r[S_DIV_Z_END] ||
                              (dz_bits_r[S_DIV_Z_END] >= 21'(EXP_ZERO_LIMIT));
      dneg_r[S_DIV_Z_END+1] <= dneg_r[S_DIV_Z_END];
      r_r                  <= nr_lo[18:3];
      n_r                  <= {nhi_r, nr_lo[2:0]};
      zero_lo_r            <= zero_hi_r;
      dneg_r[S_NR_END]     <= dneg_r[S_DIV_Z_END+1];
    end
  end

  // First series term is R itself; the running sum starts at 1 - R.
  always_ff @(posedge clk) begin
    if (en) begin
      trm_r[1]            <= {r_r, 16'h0000};
      side_r[S_SER0].rr   <= {r_r, 16'h0000};
      side_r[S_SER0].n    <= n_r;
      side_r[S_SER0].zero <= zero_lo_r;
      side_r[S_SER0].dneg <= dneg_r[S_NR_END];
      side_r[S_SER0].sum  <= (34'sd1 <<< 32) - $signed({2'b00, r_r, 16'h0000});
    end
  end

  // Each further term: multiply by R, multiply by 1/k, then correct and accumulate.
  for (genvar k = 2; k <= SERIES_TERMS; k++) begin : g_term
    localparam int B = S_SER0 + 3 * (k - 2);
    logic [63:0] prod;
    logic [67:0] prod_q;
    logic [31:0] rm;
    logic [31:0] qc;
    ser_side_t   side_nxt;

    assign prod   = 64'(trm_r[k-1]) * 64'(side_r[B].rr);
    assign prod_q = 68'(x1_r[k]) * 68'(RECIP_Q36[k]);
    assign rm     = x2_r[k] - q2_r[k] * 32'(k);
    assign qc     = (rm >= 32'(k)) ? q2_r[k] + 32'd1 : q2_r[k];

    always_comb begin
      side_nxt = side_r[B+2];
      if ((k & 1) == 1) begin
        side_nxt.sum = side_r[B+2].sum - $signed({2'b00, qc});
      end else begin
        side_nxt.sum = side_r[B+2].sum + $signed({2'b00, qc});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x1_r[k]     <= prod[63:32];
        side_r[B+1] <= side_r[B];
        q2_r[k]     <= prod_q[RECIP_SHIFT+31:RECIP_SHIFT];
        x2_r[k]     <= x1_r[k];
        side_r[B+2] <= side_r[B+1];
        side_r[B+3] <= side_nxt;
      end
    end

    if (k < SERIES_TERMS) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          trm_r[k] <= qc;
        end
      end
    end
  end

  // Scale by 2^-n to get E, then form numerator and denominator 2^32 + E.
  always_ff @(posedge clk) begin
    if (en) begin
      e_r        <= side_r[S_SER_END].zero ? 33'd0 :
                    33'(side_r[S_SER_END].sum[32:0] >> side_r[S_SER_END].n);
      dneg_den_r <= side_r[S_SER_END].dneg;
    end
  end

  assign num = dneg_den_r ? 64'(cfg_i.max_rate) * 64'(e_r) :
                            {1'b0, cfg_i.max_rate, 32'h0000_0000};

  always_ff @(posedge clk) begin
    if (en) begin
      dr_rem_r[S_NUM]  <= {1'b0, num[62:31]};
      dr_bits_r[S_NUM] <= num[30:0];
      den_r[S_NUM]     <= {2'b01, 32'd0} + {1'b0, e_r};
    end
  end

  // Rate divider: the quotient never exceeds max_rate, so 31 steps suffice.
  for (genvar s = S_NUM + 1; s <= PIPE_DEPTH; s++) begin : g_div_r
    logic [33:0] cat;
    logic        ge;
    assign cat = {dr_rem_r[s-1], dr_bits_r[s-1][30]};
    assign ge  = cat >= den_r[s-1];
    always_ff @(posedge clk) begin
      if (en) begin
        dr_bits_r[s] <= {dr_bits_r[s-1][29:0], ge};
      end
    end
    if (s < PIPE_DEPTH) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          dr_rem_r[s] <= ge ? 33'(cat - den_r[s-1]) : cat[32:0];
          den_r[s]    <= den_r[s-1];
        end
      end
    end
  end

  assign rate_o = dr_bits_r[PIPE_DEPTH];

endmodule

// ----- hw/rtl/neural_firing_response.sv -----
// Top level of the firing response block: registers, polynomial path and stream control.
// Throughput: one request per cycle while the output buffer has room; all modes share one
// fixed-depth pipeline of 99 stages set by the two restoring dividers and the 14-term series.
// A two-entry output buffer lets the pipeline keep moving while a result waits.
// Reset (synchronous, rst_n low) clears valid bits and the configuration
// registers; there is no clearing pass.
module neural_firing_response
  import nfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] soma_potential
  input  logic        in_tlast,   // last_node
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] firing_rate
  output logic        out_tlast,  // last_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  mode_t              mode_r;
  logic signed [31:0] thresh_r;
  logic [30:0]        spread_r;
  logic [30:0]        max_rate_r;
  logic signed [31:0] coef_a_r;
  logic signed [31:0] coef_b_r;
  logic signed [31:0] coef_c_r;
  logic signed [31:0] coef_d_r;
  sig_cfg_t           sig_cfg;

  logic               en;
  logic               fin;
  logic               vld_r [1:PIPE_DEPTH];
  logic               last_r [1:PIPE_DEPTH];
  logic signed [31:0] v_r;
  logic [30:0]        rate;

  logic [31:0]        absv;
  logic [63:0]        vsq;
  logic [31:0]        uv_s2_r, uv_s3_r, uv_s4_r;
  logic [39:0]        uv2_s2_r, uv2_s3_r, uv2_s4_r;
  logic               vneg_s2_r, vneg_s3_r, vneg_s4_r;
  logic [47:0]        hi_s3_r;
  logic [55:0]        lo_s3_r;
  logic [47:0]        uv3_s4_r;

  logic [47:0]        tx [0:2];
  logic               txn [0:2];
  logic signed [31:0] tc [0:2];
  logic signed [31:0] cst;
  logic [55:0]        hi_s5_r [0:2];
  logic [55:0]        lo_s5_r [0:2];
  logic               neg_s5_r [0:2];
  logic signed [31:0] cst_s5_r;
  logic signed [57:0] term_s6_r [0:2];
  logic signed [31:0] cst_s6_r;
  logic signed [59:0] sum_s7_r;
  logic [31:0]        poly_r [POLY_STAGE:PIPE_DEPTH];

  logic [31:0]        res;
  logic               out_vld_r;
  logic [31:0]        out_data_r;
  logic               out_last_r;
  logic               skid_vld_r;
  logic [31:0]        skid_data_r;
  logic               skid_last_r;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_SIGMOID;
      thresh_r   <= '0;
      spread_r   <= 31'd16777216;
      max_rate_r <= '0;
      coef_a_r   <= '0;
      coef_b_r   <= '0;
      coef_c_r   <= '0;
      coef_d_r   <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MODE:      mode_r     <= mode_t'(cfg_data[1:0]);
        REG_THRESHOLD: thresh_r   <= cfg_data;
        REG_SPREAD:    spread_r   <= cfg_data[30:0];
        REG_MAX_RATE:  max_rate_r <= cfg_data[30:0];
        REG_COEF_A:    coef_a_r   <= cfg_data;
        REG_COEF_B:    coef_b_r   <= cfg_data;
        REG_COEF_C:    coef_c_r   <= cfg_data;
        REG_COEF_D:    coef_d_r   <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign sig_cfg = '{threshold: thresh_r, spread: spread_r, max_rate: max_rate_r};

  // The whole pipeline moves together unless the output buffer is full.
  assign en        = !skid_vld_r;
  assign in_tready = en;
  assign fin       = en && vld_r[PIPE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= PIPE_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[1] <= in_tvalid;
      for (int i = 2; i <= PIPE_DEPTH; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r       <= in_tdata;
      last_r[1] <= in_tlast;
      for (int i = 2; i <= PIPE_DEPTH; i++) begin
        last_r[i] <= last_r[i-1];
      end
    end
  end

  nfr_sigmoid u_sigmoid (
    .clk    (clk),
    .en     (en),
    .v_i    (v_r),
    .cfg_i  (sig_cfg),
    .rate_o (rate)
  );

  // Powers of v as magnitudes in Q.24: v^2 first, then v^3 in two partial products.
  assign absv = v_r[31] ? 32'(-v_r) : 32'(v_r);
  assign vsq  = 64'(absv) * 64'(absv);

  always_ff @(posedge clk) begin
    if (en) begin
      uv_s2_r   <= absv;
      uv2_s2_r  <= vsq[63:24];
      vneg_s2_r <= v_r[31];
      hi_s3_r   <= 48'(uv2_s2_r[39:24]) * 48'(uv_s2_r);
      lo_s3_r   <= 56'(uv2_s2_r[23:0]) * 56'(uv_s2_r);
      uv_s3_r   <= uv_s2_r;
      uv2_s3_r  <= uv2_s2_r;
      vneg_s3_r <= vneg_s2_r;
      uv3_s4_r  <= hi_s3_r + 48'(lo_s3_r[55:24]);
      uv_s4_r   <= uv_s3_r;
      uv2_s4_r  <= uv2_s3_r;
      vneg_s4_r <= vneg_s3_r;
    end
  end

  // Pair each power with its coefficient for the configured mode.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      tx[i]  = '0;
      txn[i] = 1'b0;
      tc[i]  = '0;
    end
    cst = '0;
    unique case (mode_r)
      MODE_LINEAR: begin
        tx[0] = {16'h0000, uv_s4_r}; txn[0] = vneg_s4_r; tc[0] = coef_a_r;
        cst   = coef_b_r;
      end
      MODE_QUAD: begin
        tx[0] = {8'h00, uv2_s4_r};   tc[0] = coef_a_r;
        tx[1] = {16'h0000, uv_s4_r}; txn[1] = vneg_s4_r; tc[1] = coef_b_r;
        cst   = coef_c_r;
      end
      MODE_CUBIC: begin
        tx[0] = uv3_s4_r;            txn[0] = vneg_s4_r; tc[0] = coef_a_r;
        tx[1] = {8'h00, uv2_s4_r};   tc[1] = coef_b_r;
        tx[2] = {16'h0000, uv_s4_r}; txn[2] = vneg_s4_r; tc[2] = coef_c_r;
        cst   = coef_d_r;
      end
      default: ;
    endcase
  end

  // Each term is trunc(|x| * |coef| / 2^24) split into high and low partial products.
  for (genvar t = 0; t < 3; t++) begin : g_term
    logic [31:0] uc;
    logic [55:0] mag;
    assign uc  = tc[t][31] ? 32'(-tc[t]) : 32'(tc[t]);
    assign mag = hi_s5_r[t] + 56'(lo_s5_r[t][55:24]);
    always_ff @(posedge clk) begin
      if (en) begin
        hi_s5_r[t]   <= 56'(tx[t][47:24]) * 56'(uc);
        lo_s5_r[t]   <= 56'(tx[t][23:0]) * 56'(uc);
        neg_s5_r[t]  <= txn[t] ^ tc[t][31];
        term_s6_r[t] <= neg_s5_r[t] ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
      end
    end
  end

  // Exact sum of the terms, then clamp to 32 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      cst_s5_r <= cst;
      cst_s6_r <= cst_s5_r;
      sum_s7_r <= 60'(term_s6_r[0]) + 60'(term_s6_r[1]) + 60'(term_s6_r[2]) +
                  60'(cst_s6_r);
      if (sum_s7_r > 60'sd2147483647) begin
        poly_r[POLY_STAGE] <= 32'h7FFF_FFFF;
      end else if (sum_s7_r < -60'sd2147483648) begin
        poly_r[POLY_STAGE] <= 32'h8000_0000;
      end else begin
        poly_r[POLY_STAGE] <= sum_s7_r[31:0];
      end
      for (int i = POLY_STAGE + 1; i <= PIPE_DEPTH; i++) begin
        poly_r[i] <= poly_r[i-1];
      end
    end
  end

  assign res = (mode_r == MODE_SIGMOID) ? {1'b0, rate} : poly_r[PIPE_DEPTH];

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_vld_r && !out_tready) begin
      if (fin) begin
        skid_vld_r <= 1'b1;
      end
    end else if (skid_vld_r) begin
      out_vld_r  <= 1'b1;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (out_vld_r && !out_tready) begin
      if (fin) begin
        skid_data_r <= res;
        skid_last_r <= last_r[PIPE_DEPTH];
      end
    end else if (skid_vld_r) begin
      out_data_r <= skid_data_r;
      out_last_r <= skid_last_r;
    end else if (fin) begin
      out_data_r <= res;
      out_last_r <= last_r[PIPE_DEPTH];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The skid entry is only ever used behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid entry valid without a valid output register");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_tready))
    else $error("skid entry filled while the output was free");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && out_tready) |=> (out_vld_r && !skid_vld_r))
    else $error("skid entry did not move to the output register");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> vld_r[1])
    else $error("accepted request missing from the first stage");

endmodule

// ----- tb/nfr_firing_checker.sv -----
// Checker for the firing response block: watches the streams, predicts each rate and compares.
`timescale 1ns / 100ps

module nfr_firing_checker
  import nfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic [31:0] rate;
    logic        last;
  } rate_item_t;

  // Local copy of the configuration registers.
  mode_t              mode_r;
  logic signed [63:0] thresh_r;
  logic [63:0]        spread_r;
  logic [63:0]        max_rate_r;
  logic signed [63:0] ka, kb, kc, kd;

  rate_item_t rate_q[$];

  // Signed product scaled down by 2^24, truncated toward zero.
  function automatic logic signed [63:0] scale_q24(input logic signed [63:0] x,
                                                   input logic signed [63:0] y);
    logic [63:0]  mx;
    logic [63:0]  my;
    logic [127:0] p;
    logic signed [63:0] m;
    mx = x < 0 ? -x : x;
    my = y < 0 ? -y : y;
    p = {64'd0, mx} * {64'd0, my};
    m = p[87:24];
    return ((x < 0) != (y < 0)) ? -m : m;
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // exp(-z / 2^16) in Q.32 by range reduction on ln 2 and a truncated series.
  function automatic logic [63:0] decay_q32(input logic [63:0] z);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] rr;
    logic [63:0] t;
    logic signed [63:0] acc;
    n = z / LN2_Q16;
    r = z - n * LN2_Q16;
    rr = r << 16;
    t = 64'd1 << 32;
    acc = t;
    if (n > 32) return 64'd0;
    for (int k = 1; k <= SERIES_TERMS; k++) begin
      t = ((t * rr) >> 32) / k;
      if (k % 2 == 1) acc = acc - t;
      else acc = acc + t;
    end
    return acc >> n;
  endfunction

  function automatic logic [31:0] sigmoid_rate(input logic signed [63:0] v);
    logic signed [63:0] dv;
    logic [63:0] s;
    logic [63:0] z;
    logic [63:0] e;
    logic [63:0] den;
    dv = v - thresh_r;
    s = spread_r == 0 ? 64'd1 : spread_r;
    z = ((dv < 0 ? -dv : dv) << 16) / s;
    e = decay_q32(z);
    den = (64'd1 << 32) + e;
    if (dv >= 0) return 32'((max_rate_r << 32) / den);
    return 32'((max_rate_r * e) / den);
  endfunction

  function automatic logic [31:0] firing_rate(input logic [31:0] raw);
    logic signed [63:0] v;
    logic signed [63:0] v2;
    logic signed [63:0] v3;
    v = 64'(signed'(raw));
    v2 = scale_q24(v, v);
    v3 = scale_q24(v2, v);
    case (mode_r)
      MODE_SIGMOID: return sigmoid_rate(v);
      MODE_LINEAR:  return clamp32(scale_q24(v, ka) + kb);
      MODE_QUAD:    return clamp32(scale_q24(v2, ka) + scale_q24(v, kb) + kc);
      default:      return clamp32(scale_q24(v3, ka) + scale_q24(v2, kb) +
                                   scale_q24(v, kc) + kd);
    endcase
  endfunction

  initial begin
    mismatches = 0;
    pending = 0;
  end

  // Track configuration, queue expected rates and compare each returned result.
  always @(posedge clk) begin
    rate_item_t want;
    if (!rst_n) begin
      mode_r = MODE_SIGMOID;
      thresh_r = 0;
      spread_r = 64'd16777216;
      max_rate_r = 0;
      ka = 0;
      kb = 0;
      kc = 0;
      kd = 0;
      rate_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_MODE:      mode_r = mode_t'(cfg_data[1:0]);
          REG_THRESHOLD: thresh_r = 64'(signed'(cfg_data));
          REG_SPREAD:    spread_r = {33'd0, cfg_data[30:0]};
          REG_MAX_RATE:  max_rate_r = {33'd0, cfg_data[30:0]};
          REG_COEF_A:    ka = 64'(signed'(cfg_data));
          REG_COEF_B:    kb = 64'(signed'(cfg_data));
          REG_COEF_C:    kc = 64'(signed'(cfg_data));
          REG_COEF_D:    kd = 64'(signed'(cfg_data));
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        rate_q.push_back('{rate: firing_rate(in_tdata), last: in_tlast});
      if (out_tvalid && out_tready) begin
        if (rate_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result rate=%h last=%b", out_tdata, out_tlast);
        end else begin
          want = rate_q.pop_front();
          if (want.rate !== out_tdata || want.last !== out_tlast) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected rate=%h last=%b, got rate=%h last=%b",
                       want.rate, want.last, out_tdata, out_tlast);
          end
        end
      end
    end
    pending = rate_q.size();
  end

endmodule

// ----- tb/tb_neural_firing_response.sv -----
// Testbench top for the firing response block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_neural_firing_response;
  import nfr_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] soma_potential
  logic        in_tlast;   // last_node
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] firing_rate
  logic        out_tlast;  // last_out
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          mismatches;
  int          pending;

  neural_firing_response dut (.*);

  nfr_firing_checker chk (.*);

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Generous overall time limit.
  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: mostly ready, short stalls, now and then a long one.
  initial begin
    int pick;
    out_tready = 1'b0;
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(negedge clk);
      end else if (pick < 95) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One request; a random gap may come first, so valid stays high when there is none.
  task automatic send_potential(input logic [31:0] v, input logic last);
    int pick;
    int gap;
    @(negedge clk);
    pick = $urandom_range(0, 99);
    gap = pick < 55 ? 0 : (pick < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= v;
    in_tlast <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drain the pipeline so configuration may change.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (110) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_potential(input logic [31:0] thr);
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      2: return thr + 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) >>> $urandom_range(0, 20))
                      ^ {32{$urandom_range(0, 1) == 1}};
    endcase
  endfunction

  // Field extremes, unit steps and points around the threshold, then random potentials.
  task automatic run_phase(input logic [31:0] thr, input int count);
    logic [31:0] edges [10];
    edges = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h0100_0000, 32'hFF00_0000, thr, thr + 32'h1, thr - 32'h1};
    foreach (edges[i]) send_potential(edges[i], i[0]);
    repeat (count) send_potential(pick_potential(thr), $urandom_range(0, 1));
    drain();
  endtask

  task automatic set_sigmoid(input logic [31:0] thr, input logic [31:0] spr,
                             input logic [31:0] mx);
    write_reg(REG_MODE, 32'(MODE_SIGMOID));
    write_reg(REG_THRESHOLD, thr);
    write_reg(REG_SPREAD, spr);
    write_reg(REG_MAX_RATE, mx);
  endtask

  task automatic set_poly(input mode_t m, input logic [31:0] a, input logic [31:0] b,
                          input logic [31:0] c, input logic [31:0] d);
    write_reg(REG_MODE, 32'(m));
    write_reg(REG_COEF_A, a);
    write_reg(REG_COEF_B, b);
    write_reg(REG_COEF_C, c);
    write_reg(REG_COEF_D, d);
  endtask

  initial begin
    logic [31:0] thr;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Settings after reset.
    run_phase(32'h0, 40);

    // Sigmoid: unit spread, a zero spread, the widest spread and random settings.
    set_sigmoid(32'h0, 32'h0100_0000, 32'h0064_0000);
    run_phase(32'h0, 150);
    thr = $urandom;
    set_sigmoid(thr, 32'h0, 32'h7FFF_FFFF);
    run_phase(thr, 120);
    set_sigmoid(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    run_phase(32'h8000_0000, 100);
    repeat (3) begin
      thr = pick_potential(32'h0);
      set_sigmoid(thr, $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 24),
                  $urandom_range(0, 32'h7FFF_FFFF));
      run_phase(thr, 110);
    end
    set_sigmoid(32'h7FFF_FFFF, 32'h1, 32'h0001_0000);
    run_phase(32'h7FFF_FFFF, 60);

    // Polynomial modes, including coefficients that drive the sum into saturation.
    set_poly(MODE_LINEAR, 32'h0001_0000, 32'h0, 32'h0, 32'h0);
    run_phase(32'h0, 100);
    set_poly(MODE_LINEAR, 32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom);
    run_phase(32'h0, 100);
    set_poly(MODE_QUAD, $urandom, $urandom, $urandom, $urandom);
    run_phase(32'h0, 120);
    set_poly(MODE_QUAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0);
    run_phase(32'h0, 80);
    set_poly(MODE_CUBIC, $urandom, $urandom, $urandom, $urandom);
    run_phase(32'h0, 120);
    set_poly(MODE_CUBIC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    run_phase(32'h0, 80);
    set_poly(MODE_CUBIC, $urandom_range(0, 32'h3_FFFF) - 32'h2_0000,
             $urandom_range(0, 32'h3_FFFF) - 32'h2_0000, $urandom, $urandom);
    run_phase(32'h0, 120);
    set_poly(MODE_LINEAR, $urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(32'h0, 100);

    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/nfr_pkg.sv
hw/rtl/nfr_sigmoid.sv
hw/rtl/neural_firing_response.sv
tb/nfr_firing_checker.sv
tb/tb_neural_firing_response.sv
